// ===== sv/mpf_pkg.sv =====
// Shared constants for the page-organised monochrome frame store.
// Holds command and colour codes and the fixed field widths.
// No dependencies.
package mpf_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned COLOUR_W = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned DW_W     = 8;
  localparam int unsigned DH_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned PAGE_ROWS = 8;

  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  localparam logic [COLOUR_W-1:0] COL_BLACK   = 2'd0;
  localparam logic [COLOUR_W-1:0] COL_WHITE   = 2'd1;
  localparam logic [COLOUR_W-1:0] COL_INVERSE = 2'd2;
  localparam logic [COLOUR_W-1:0] COL_NONE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

endpackage

// ===== sv/mono_page_framebuffer_top.sv =====
// Top level of the page-organised monochrome frame store.
// Holds the frame memory, the read pointer and the command sequencer.
// Depends on mpf_pkg.
//
// A draw word reads its memory entry when taken and writes it back in the draw
// state; a read word reads its entry when taken and loads the output register
// in the read state, since the single frame memory has one registered read
// port. A read word waits further while the previous result is still held by
// the output. Draw words that fall off the panel, use colour three or carry an
// unused command leave the block idle. A clear word, and reset, sweep the whole
// store one entry per cycle, all MAX_WIDTH * ceil(MAX_HEIGHT / 8) entries (1024
// with the default parameters), taking no input word meanwhile. Configuration
// writes are taken at any time and must only be issued while the block is idle.
module mono_page_framebuffer_top #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [mpf_pkg::CMD_W-1:0]            command,
  input  logic signed [mpf_pkg::COORD_W-1:0]   pos_x,
  input  logic signed [mpf_pkg::COORD_W-1:0]   pos_y,
  input  logic [mpf_pkg::COLOUR_W-1:0]         colour,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mpf_pkg::BYTE_W-1:0]           pixel_byte,
  output logic [mpf_pkg::IDX_W-1:0]            byte_index,
  output logic                                 last_byte,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mpf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mpf_pkg::DW_W-1:0]             cfg_data
);

  localparam int unsigned MAX_PAGES = (MAX_HEIGHT + mpf_pkg::PAGE_ROWS - 1) /
                                      mpf_pkg::PAGE_ROWS;
  localparam int unsigned DEPTH     = MAX_WIDTH * MAX_PAGES;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned SIZE_W    = $clog2(DEPTH + 1);
  localparam int unsigned PAGE_W    = mpf_pkg::DH_W - 3;
  localparam int unsigned NPAGE_W   = mpf_pkg::DH_W - 2;
  localparam int unsigned PROD_W    = mpf_pkg::DW_W + NPAGE_W;
  localparam int unsigned DADDR_W   = mpf_pkg::DW_W + PAGE_W + 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW,
    ST_READ
  } state_t;

  state_t state;

  // Configuration registers.
  logic [mpf_pkg::DW_W-1:0] display_width;
  logic [mpf_pkg::DH_W-1:0] display_height;

  // Frame memory.
  logic [mpf_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [mpf_pkg::BYTE_W-1:0] rd_q;
  logic                       mem_re;
  logic [ADDR_W-1:0]          mem_raddr;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [mpf_pkg::BYTE_W-1:0] mem_wdata;

  // Sequencer registers.
  logic [ADDR_W-1:0]            clr_addr;
  logic [ADDR_W-1:0]            read_pointer;
  logic [ADDR_W-1:0]            draw_addr;
  logic [mpf_pkg::BYTE_W-1:0]   draw_mask;
  logic [mpf_pkg::COLOUR_W-1:0] draw_colour;
  logic [ADDR_W-1:0]            rd_pos;
  logic                         rd_last;
  logic                         rd_empty;

  // Effective layout.
  logic [mpf_pkg::DW_W-1:0] eff_width;
  logic [mpf_pkg::DH_W-1:0] eff_height;
  logic [mpf_pkg::DH_W:0]   height_round;
  logic [NPAGE_W-1:0]       pages;
  logic [PROD_W-1:0]        size_prod;
  logic [SIZE_W-1:0]        frame_size;
  logic                     frame_empty;

  // Draw decode.
  logic                     x_hit;
  logic                     y_hit;
  logic                     draw_hit;
  logic [DADDR_W-1:0]       draw_addr_wide;
  logic [mpf_pkg::BYTE_W-1:0] mask_dec;

  // Read decode.
  logic                     stale;
  logic [ADDR_W-1:0]        pos;
  logic                     pos_last;
  logic [ADDR_W-1:0]        ptr_next;
  logic [ADDR_W+mpf_pkg::IDX_W-1:0] pos_wide;

  logic in_fire;
  logic out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    eff_width = ({1'b0, display_width} > (mpf_pkg::DW_W+1)'(MAX_WIDTH)) ?
                mpf_pkg::DW_W'(MAX_WIDTH) : display_width;
    eff_height = ({1'b0, display_height} > (mpf_pkg::DH_W+1)'(MAX_HEIGHT)) ?
                 mpf_pkg::DH_W'(MAX_HEIGHT) : display_height;
    height_round = {1'b0, eff_height} + (mpf_pkg::DH_W+1)'(mpf_pkg::PAGE_ROWS - 1);
    pages        = height_round[mpf_pkg::DH_W:3];
    size_prod    = PROD_W'(eff_width) * PROD_W'(pages);
    frame_size   = size_prod[SIZE_W-1:0];
    frame_empty  = (frame_size == '0);
  end

  always_comb begin
    x_hit = !pos_x[mpf_pkg::COORD_W-1] &&
            (pos_x[mpf_pkg::COORD_W-2:0] < (mpf_pkg::COORD_W-1)'(eff_width));
    y_hit = !pos_y[mpf_pkg::COORD_W-1] &&
            (pos_y[mpf_pkg::COORD_W-2:0] < (mpf_pkg::COORD_W-1)'(eff_height));
    draw_hit = x_hit && y_hit && (colour != mpf_pkg::COL_NONE);
    // Byte address is column plus page times width.
    draw_addr_wide = DADDR_W'(pos_x[mpf_pkg::DW_W-1:0]) +
                     DADDR_W'(pos_y[mpf_pkg::DH_W-1:3]) * DADDR_W'(eff_width);
    mask_dec = mpf_pkg::BYTE_W'(1) << pos_y[2:0];
  end

  always_comb begin
    stale    = (SIZE_W'(read_pointer) >= frame_size);
    pos      = stale ? '0 : read_pointer;
    pos_last = frame_empty || (SIZE_W'(pos) == frame_size - SIZE_W'(1));
    ptr_next = pos_last ? '0 : pos + ADDR_W'(1);
    pos_wide = {{mpf_pkg::IDX_W{1'b0}}, rd_pos};
  end

  always_comb begin
    mem_re    = in_fire && (command == mpf_pkg::CMD_DRAW || command == mpf_pkg::CMD_READ);
    mem_raddr = (command == mpf_pkg::CMD_READ) ? pos : draw_addr_wide[ADDR_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = draw_addr;
    mem_wdata = rd_q;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_DRAW: begin
        mem_we = 1'b1;
        case (draw_colour)
          mpf_pkg::COL_BLACK:   mem_wdata = rd_q & ~draw_mask;
          mpf_pkg::COL_WHITE:   mem_wdata = rd_q | draw_mask;
          mpf_pkg::COL_INVERSE: mem_wdata = rd_q ^ draw_mask;
          default:              mem_wdata = rd_q;
        endcase
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      display_width  <= mpf_pkg::DW_W'(128);
      display_height <= mpf_pkg::DH_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mpf_pkg::REG_WIDTH:  display_width  <= cfg_data;
        mpf_pkg::REG_HEIGHT: display_height <= cfg_data[mpf_pkg::DH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      read_pointer <= '0;
      out_valid    <= 1'b0;
    end else begin
      // The read state drives the output flag itself.
      if (out_valid && out_ready && state != ST_READ) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            clr_addr <= '0;
            state    <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + ADDR_W'(1);
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            case (command)
              mpf_pkg::CMD_DRAW: begin
                draw_addr   <= draw_addr_wide[ADDR_W-1:0];
                draw_mask   <= mask_dec;
                draw_colour <= colour;
                if (draw_hit) begin
                  state <= ST_DRAW;
                end
              end
              mpf_pkg::CMD_READ: begin
                rd_pos       <= pos;
                rd_last      <= pos_last;
                rd_empty     <= frame_empty;
                read_pointer <= ptr_next;
                state        <= ST_READ;
              end
              mpf_pkg::CMD_CLEAR: begin
                clr_addr <= '0;
                state    <= ST_CLEAR;
              end
              default: ;
            endcase
          end
        end
        ST_DRAW: begin
          state <= ST_IDLE;
        end
        ST_READ: begin
          // The memory output holds until the next read, so a stalled
          // result can wait here.
          if (out_free) begin
            out_valid  <= 1'b1;
            pixel_byte <= rd_empty ? '0 : rd_q;
            byte_index <= pos_wide[mpf_pkg::IDX_W-1:0];
            last_byte  <= rd_last;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
